// ----- rtl/core/avl_pkg.sv -----
`default_nettype none

package avl_pkg;

  // advance strobe and the valid bit of the beat that enters a unit
  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctrl_t;

  localparam logic [2:0] REG_MAX_SPEED  = 3'd0;
  localparam logic [2:0] REG_MAX_ACCEL  = 3'd1;
  localparam logic [2:0] REG_SLOW_RAD   = 3'd2;
  localparam logic [2:0] REG_MIN_SPEED  = 3'd3;
  localparam logic [2:0] REG_STOP_SPEED = 3'd4;

  localparam logic [2:0] MODE_ZERO    = 3'd0;
  localparam logic [2:0] MODE_BRAKE   = 3'd1;
  localparam logic [2:0] MODE_REACHED = 3'd2;
  localparam logic [2:0] MODE_ACCEL   = 3'd3;
  localparam logic [2:0] MODE_CLAMP   = 3'd4;

endpackage

`default_nettype wire

// ----- rtl/core/avl_sqrt.sv -----
`default_nettype none

module avl_sqrt
  import avl_pkg::*;
#(
  parameter int IW    = 50,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pipe_ctrl_t                   ctrl_i,
  input  logic [LANES-1:0][IW-1:0]     rad_i,
  input  logic [SW-1:0]                sb_i,
  output logic                         vld_o,
  output logic [LANES-1:0][IW/2-1:0]   root_o,
  output logic [SW-1:0]                sb_o
);

  localparam int RW = IW / 2;

  logic                           vld_q  [RW];
  logic [LANES-1:0][IW-1:0]       rad_q  [RW];
  logic [LANES-1:0][RW+1:0]       rem_q  [RW];
  logic [LANES-1:0][RW-1:0]       root_q [RW];
  logic [SW-1:0]                  sb_q   [RW];

  // one root bit per stage, two radicand bits shifted in
  for (genvar g = 0; g < RW; g++) begin : g_stage
    logic                     vld_p;
    logic [SW-1:0]            sb_p;
    logic [LANES-1:0][IW-1:0] rad_p;
    logic [LANES-1:0][RW+1:0] rem_p;
    logic [LANES-1:0][RW-1:0] root_p;
    logic [LANES-1:0][IW-1:0] rad_d;
    logic [LANES-1:0][RW+1:0] rem_d;
    logic [LANES-1:0][RW-1:0] root_d;
    logic [LANES-1:0][RW+1:0] cur;
    logic [LANES-1:0][RW+1:0] trial;

    if (g == 0) begin : g_first
      assign vld_p  = ctrl_i.vld;
      assign sb_p   = sb_i;
      assign rad_p  = rad_i;
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_next
      assign vld_p  = vld_q[g-1];
      assign sb_p   = sb_q[g-1];
      assign rad_p  = rad_q[g-1];
      assign rem_p  = rem_q[g-1];
      assign root_p = root_q[g-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        cur[l]   = {rem_p[l][RW-1:0], rad_p[l][IW-1 -: 2]};
        trial[l] = {root_p[l], 2'b01};
        rad_d[l] = {rad_p[l][IW-3:0], 2'b00};
        if (cur[l] >= trial[l]) begin
          rem_d[l]  = cur[l] - trial[l];
          root_d[l] = {root_p[l][RW-2:0], 1'b1};
        end else begin
          rem_d[l]  = cur[l];
          root_d[l] = {root_p[l][RW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (ctrl_i.en) begin
        vld_q[g] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.en) begin
        sb_q[g]   <= sb_p;
        rad_q[g]  <= rad_d;
        rem_q[g]  <= rem_d;
        root_q[g] <= root_d;
      end
    end
  end

  assign vld_o  = vld_q[RW-1];
  assign root_o = root_q[RW-1];
  assign sb_o   = sb_q[RW-1];

endmodule

`default_nettype wire

// ----- rtl/core/avl_div.sv -----
`default_nettype none

module avl_div
  import avl_pkg::*;
#(
  parameter int NW    = 38,
  parameter int DW    = 23,
  parameter int QW    = 16,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pipe_ctrl_t                 ctrl_i,
  input  logic [LANES-1:0][NW-1:0]   num_i,
  input  logic [LANES-1:0][DW-1:0]   den_i,
  input  logic [SW-1:0]              sb_i,
  output logic                       vld_o,
  output logic [LANES-1:0][QW-1:0]   quo_o,
  output logic [SW-1:0]              sb_o
);

  // the quotient must fit in QW bits: num < den * 2**QW
  logic                      vld_q [QW];
  logic [LANES-1:0][DW-1:0]  rem_q [QW];
  logic [LANES-1:0][QW-1:0]  nq_q  [QW];
  logic [LANES-1:0][DW-1:0]  den_q [QW];
  logic [SW-1:0]             sb_q  [QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic                     vld_p;
    logic [SW-1:0]            sb_p;
    logic [LANES-1:0][DW-1:0] rem_p;
    logic [LANES-1:0][QW-1:0] nq_p;
    logic [LANES-1:0][DW-1:0] den_p;
    logic [LANES-1:0][DW-1:0] rem_d;
    logic [LANES-1:0][QW-1:0] nq_d;
    logic [LANES-1:0][DW:0]   cur;
    logic [LANES-1:0][DW:0]   sub;
    logic [LANES-1:0]         ge;

    if (g == 0) begin : g_first
      assign vld_p = ctrl_i.vld;
      assign sb_p  = sb_i;
      assign den_p = den_i;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rem_p[l] = DW'(num_i[l] >> QW);
        assign nq_p[l]  = num_i[l][QW-1:0];
      end
    end else begin : g_next
      assign vld_p = vld_q[g-1];
      assign sb_p  = sb_q[g-1];
      assign den_p = den_q[g-1];
      assign rem_p = rem_q[g-1];
      assign nq_p  = nq_q[g-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        cur[l]   = {rem_p[l], nq_p[l][QW-1]};
        sub[l]   = cur[l] - {1'b0, den_p[l]};
        ge[l]    = cur[l] >= {1'b0, den_p[l]};
        rem_d[l] = ge[l] ? sub[l][DW-1:0] : cur[l][DW-1:0];
        nq_d[l]  = {nq_p[l][QW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (ctrl_i.en) begin
        vld_q[g] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.en) begin
        sb_q[g]  <= sb_p;
        den_q[g] <= den_p;
        rem_q[g] <= rem_d;
        nq_q[g]  <= nq_d;
      end
    end
  end

  assign vld_o = vld_q[QW-1];
  assign quo_o = nq_q[QW-1];
  assign sb_o  = sb_q[QW-1];

endmodule

`default_nettype wire

// ----- rtl/core/arrival_velocity_limiter.sv -----
// Pipeline: 136 register stages, set by three square-root pipelines
// and four dividers in series.
// Throughput: one item per cycle; a stall at the output holds every stage in place.
// Reset: asynchronous, active low; empties the pipeline and loads the register
// defaults (max speed 2.5, max accel 4.0, slow radius 0.5, floor 0.1, stop 0.01).
`default_nettype none

module arrival_velocity_limiter
  import avl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               tracked_i,
  input  logic signed [23:0] target_x_i,
  input  logic signed [23:0] target_y_i,
  input  logic signed [23:0] target_z_i,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic signed [23:0] pos_z_i,
  input  logic signed [15:0] vel_x_i,
  input  logic signed [15:0] vel_y_i,
  input  logic signed [15:0] vel_z_i,
  input  logic [15:0]        step_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] new_vel_x_o,
  output logic signed [15:0] new_vel_y_o,
  output logic signed [15:0] new_vel_z_o,
  output logic [2:0]         mode_o
);

  typedef struct packed {
    logic            live;
    logic [2:0][23:0] dmag;
    logic [2:0]       dneg;
    logic [2:0][15:0] vel;
    logic [2:0][15:0] vmag;
    logic [15:0]      dv;
  } front_t;

  typedef struct packed {
    logic             live;
    logic [2:0][23:0] dmag;
    logic [2:0]       dneg;
    logic [2:0][15:0] vel;
    logic [15:0]      dv;
    logic [24:0]      dlen;
    logic [16:0]      spv;
    logic             near;
  } speed_t;

  typedef struct packed {
    logic             live;
    logic [2:0]       dneg;
    logic [2:0][15:0] vel;
    logic [15:0]      dv;
    logic             at_tgt;
    logic             brake_ok;
    logic [2:0][15:0] rb;
  } want_sb_t;

  typedef struct packed {
    logic             live;
    logic [2:0][15:0] vel;
    logic [15:0]      dv;
    logic             at_tgt;
    logic             brake_ok;
    logic [2:0][15:0] rb;
    logic [2:0][15:0] want;
    logic [2:0]       fneg;
    logic [2:0][16:0] fmag;
  } diff_sb_t;

  typedef struct packed {
    logic             live;
    logic [2:0][15:0] vel;
    logic             at_tgt;
    logic             brake_ok;
    logic [2:0][15:0] rb;
    logic [2:0][15:0] want;
    logic             reach;
    logic [2:0]       fneg;
  } step_sb_t;

  typedef struct packed {
    logic             live;
    logic             at_tgt;
    logic             brake_ok;
    logic [2:0][15:0] rb;
    logic [2:0][15:0] want;
    logic             reach;
    logic [2:0][15:0] rv;
    logic [2:0]       rneg;
    logic [2:0][15:0] rmag;
  } new_sb_t;

  typedef struct packed {
    logic             live;
    logic             at_tgt;
    logic             brake_ok;
    logic [2:0][15:0] rb;
    logic [2:0][15:0] want;
    logic             reach;
    logic [2:0][15:0] rv;
    logic [2:0]       rneg;
    logic             clamp;
  } clamp_sb_t;

  // ---------------------------------------------------------------- registers
  logic [14:0] max_speed_q;
  logic [15:0] max_accel_q;
  logic [22:0] slow_radius_q;
  logic [14:0] min_speed_q;
  logic [14:0] stop_speed_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q   <= 15'd10240;
      max_accel_q   <= 16'd16384;
      slow_radius_q <= 23'd2048;
      min_speed_q   <= 15'd410;
      stop_speed_q  <= 15'd41;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_MAX_SPEED:  max_speed_q   <= pwdata[14:0];
        REG_MAX_ACCEL:  max_accel_q   <= pwdata[15:0];
        REG_SLOW_RAD:   slow_radius_q <= pwdata[22:0];
        REG_MIN_SPEED:  min_speed_q   <= pwdata[14:0];
        REG_STOP_SPEED: stop_speed_q  <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_MAX_SPEED:  prdata = {17'd0, max_speed_q};
      REG_MAX_ACCEL:  prdata = {16'd0, max_accel_q};
      REG_SLOW_RAD:   prdata = {9'd0, slow_radius_q};
      REG_MIN_SPEED:  prdata = {17'd0, min_speed_q};
      REG_STOP_SPEED: prdata = {17'd0, stop_speed_q};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- pipeline
  logic adv;
  logic out_valid_q;

  // the whole pipeline moves together; hold everything while the output beat waits
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q, v11_q, v12_q;
  logic vld_a, vld_b, vld_c, vld_d, vld_e, vld_f, vld_g;

  // stage 0: differences, magnitudes, velocity step
  front_t           f0_d, f0_q, f1_q, f2_q, f_a;
  logic [2:0][24:0] dlt0;
  logic [2:0][24:0] dabs0;
  logic [2:0][15:0] vel0;
  logic [31:0]      dvp0;

  always_comb begin
    dlt0[0] = {target_x_i[23], target_x_i} - {pos_x_i[23], pos_x_i};
    dlt0[1] = {target_y_i[23], target_y_i} - {pos_y_i[23], pos_y_i};
    dlt0[2] = {target_z_i[23], target_z_i} - {pos_z_i[23], pos_z_i};
    vel0    = {vel_z_i, vel_y_i, vel_x_i};
    dvp0    = max_accel_q * step_time_i;
    f0_d.live = tracked_i & (step_time_i != 16'd0);
    f0_d.dv   = dvp0[31:16];
    for (int i = 0; i < 3; i++) begin
      dabs0[i]     = dlt0[i][24] ? 25'd0 - dlt0[i] : dlt0[i];
      f0_d.dneg[i] = dlt0[i][24];
      f0_d.dmag[i] = dabs0[i][23:0];
      f0_d.vel[i]  = vel0[i];
      f0_d.vmag[i] = vel0[i][15] ? 16'd0 - vel0[i] : vel0[i];
    end
  end

  // stages 1 and 2: squares, then sums
  logic [2:0][47:0] sqd1_q;
  logic [2:0][31:0] sqv1_q;
  logic [49:0]      sd2_q;
  logic [31:0]      sv2_q;

  // square-root pipeline: distance and current speed
  pipe_ctrl_t       ctrl_a;
  logic [1:0][49:0] rad_a;
  logic [1:0][24:0] root_a;

  assign ctrl_a = '{en: adv, vld: v2_q};
  assign rad_a  = {50'(sv2_q), sd2_q};

  avl_sqrt #(.IW(50), .LANES(2), .SW($bits(front_t))) u_sqrt_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl_a),
    .rad_i  (rad_a),
    .sb_i   (f2_q),
    .vld_o  (vld_a),
    .root_o (root_a),
    .sb_o   (f_a)
  );

  // stage 3: numerators of approach speed and braking step
  speed_t           sp3_d, sp3_q, sp_b;
  logic [37:0]      nump3_d, nump3_q;
  logic [2:0][31:0] bnum3_d, bnum3_q;

  always_comb begin
    sp3_d.live = f_a.live;
    sp3_d.dmag = f_a.dmag;
    sp3_d.dneg = f_a.dneg;
    sp3_d.vel  = f_a.vel;
    sp3_d.dv   = f_a.dv;
    sp3_d.dlen = root_a[0];
    sp3_d.spv  = root_a[1][16:0];
    sp3_d.near = root_a[0] < {2'b00, slow_radius_q};
    nump3_d    = max_speed_q * root_a[0][22:0];
    for (int i = 0; i < 3; i++) begin
      bnum3_d[i] = f_a.vmag[i] * f_a.dv;
    end
  end

  pipe_ctrl_t       ctrl_b;
  logic [3:0][37:0] num_b;
  logic [3:0][22:0] den_b;
  logic [3:0][15:0] quo_b;

  assign ctrl_b = '{en: adv, vld: v3_q};
  assign num_b  = {38'(bnum3_q[2]), 38'(bnum3_q[1]), 38'(bnum3_q[0]), nump3_q};
  assign den_b  = {23'(sp3_q.spv), 23'(sp3_q.spv), 23'(sp3_q.spv), slow_radius_q};

  avl_div #(.NW(38), .DW(23), .QW(16), .LANES(4), .SW($bits(speed_t))) u_div_speed (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl_b),
    .num_i  (num_b),
    .den_i  (den_b),
    .sb_i   (sp3_q),
    .vld_o  (vld_b),
    .quo_o  (quo_b),
    .sb_o   (sp_b)
  );

  // stage 4: desired speed, braking result, desired-velocity numerators
  want_sb_t         w4_d, w4_q, w_c;
  logic [2:0][38:0] wnum4_d, wnum4_q;
  logic [24:0]      dist4_q;
  logic [14:0]      spd4;
  logic [14:0]      spd4_lo;

  always_comb begin
    spd4_lo = (quo_b[0][14:0] < min_speed_q) ? min_speed_q : quo_b[0][14:0];
    spd4    = sp_b.near ? spd4_lo : max_speed_q;
    w4_d.live     = sp_b.live;
    w4_d.dneg     = sp_b.dneg;
    w4_d.vel      = sp_b.vel;
    w4_d.dv       = sp_b.dv;
    w4_d.at_tgt   = sp_b.dlen == 25'd0;
    w4_d.brake_ok = !((sp_b.spv < {2'b00, stop_speed_q}) || (sp_b.spv == 17'd0) ||
                      ({1'b0, sp_b.dv} > sp_b.spv));
    for (int i = 0; i < 3; i++) begin
      w4_d.rb[i] = sp_b.vel[i][15] ? sp_b.vel[i] + quo_b[i+1] : sp_b.vel[i] - quo_b[i+1];
      wnum4_d[i] = sp_b.dmag[i] * spd4;
    end
  end

  pipe_ctrl_t       ctrl_c;
  logic [2:0][24:0] den_c;
  logic [2:0][15:0] quo_c;

  assign ctrl_c = '{en: adv, vld: v4_q};
  assign den_c  = {dist4_q, dist4_q, dist4_q};

  avl_div #(.NW(39), .DW(25), .QW(16), .LANES(3), .SW($bits(want_sb_t))) u_div_want (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl_c),
    .num_i  (wnum4_q),
    .den_i  (den_c),
    .sb_i   (w4_q),
    .vld_o  (vld_c),
    .quo_o  (quo_c),
    .sb_o   (w_c)
  );

  // stage 5: desired velocity and its difference from the current one
  diff_sb_t         df5_d, df5_q, df6_q, df7_q, df_d;
  logic [2:0][16:0] diff5;
  logic [2:0][33:0] sqf6_q;
  logic [33:0]      sf7_q;

  always_comb begin
    df5_d.live     = w_c.live;
    df5_d.vel      = w_c.vel;
    df5_d.dv       = w_c.dv;
    df5_d.at_tgt   = w_c.at_tgt;
    df5_d.brake_ok = w_c.brake_ok;
    df5_d.rb       = w_c.rb;
    for (int i = 0; i < 3; i++) begin
      df5_d.want[i] = w_c.dneg[i] ? 16'd0 - quo_c[i] : quo_c[i];
      diff5[i]      = {df5_d.want[i][15], df5_d.want[i]} - {w_c.vel[i][15], w_c.vel[i]};
      df5_d.fneg[i] = diff5[i][16];
      df5_d.fmag[i] = diff5[i][16] ? 17'd0 - diff5[i] : diff5[i];
    end
  end

  pipe_ctrl_t       ctrl_d;
  logic [0:0][33:0] rad_d;
  logic [0:0][16:0] root_d;

  assign ctrl_d = '{en: adv, vld: v7_q};
  assign rad_d  = sf7_q;

  avl_sqrt #(.IW(34), .LANES(1), .SW($bits(diff_sb_t))) u_sqrt_diff (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl_d),
    .rad_i  (rad_d),
    .sb_i   (df7_q),
    .vld_o  (vld_d),
    .root_o (root_d),
    .sb_o   (df_d)
  );

  // stage 8: reach test and acceleration-step numerators
  step_sb_t         st8_d, st8_q, st_e;
  logic [2:0][32:0] cnum8_d, cnum8_q;
  logic [16:0]      dm8_q;

  always_comb begin
    st8_d.live     = df_d.live;
    st8_d.vel      = df_d.vel;
    st8_d.at_tgt   = df_d.at_tgt;
    st8_d.brake_ok = df_d.brake_ok;
    st8_d.rb       = df_d.rb;
    st8_d.want     = df_d.want;
    st8_d.reach    = root_d[0] <= {1'b0, df_d.dv};
    st8_d.fneg     = df_d.fneg;
    for (int i = 0; i < 3; i++) begin
      cnum8_d[i] = df_d.fmag[i] * df_d.dv;
    end
  end

  pipe_ctrl_t       ctrl_e;
  logic [2:0][16:0] den_e;
  logic [2:0][15:0] quo_e;

  assign ctrl_e = '{en: adv, vld: v8_q};
  assign den_e  = {dm8_q, dm8_q, dm8_q};

  avl_div #(.NW(33), .DW(17), .QW(16), .LANES(3), .SW($bits(step_sb_t))) u_div_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl_e),
    .num_i  (cnum8_q),
    .den_i  (den_e),
    .sb_i   (st8_q),
    .vld_o  (vld_e),
    .quo_o  (quo_e),
    .sb_o   (st_e)
  );

  // stage 9: accelerated velocity
  new_sb_t          n9_d, n9_q, n10_q, n11_q, n_f;
  logic [2:0][31:0] sqr10_q;
  logic [31:0]      sr11_q;

  always_comb begin
    n9_d.live     = st_e.live;
    n9_d.at_tgt   = st_e.at_tgt;
    n9_d.brake_ok = st_e.brake_ok;
    n9_d.rb       = st_e.rb;
    n9_d.want     = st_e.want;
    n9_d.reach    = st_e.reach;
    for (int i = 0; i < 3; i++) begin
      n9_d.rv[i]   = st_e.fneg[i] ? st_e.vel[i] - quo_e[i] : st_e.vel[i] + quo_e[i];
      n9_d.rneg[i] = n9_d.rv[i][15];
      n9_d.rmag[i] = n9_d.rv[i][15] ? 16'd0 - n9_d.rv[i] : n9_d.rv[i];
    end
  end

  pipe_ctrl_t       ctrl_f;
  logic [0:0][31:0] rad_f;
  logic [0:0][15:0] root_f;

  assign ctrl_f = '{en: adv, vld: v11_q};
  assign rad_f  = sr11_q;

  avl_sqrt #(.IW(32), .LANES(1), .SW($bits(new_sb_t))) u_sqrt_new (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl_f),
    .rad_i  (rad_f),
    .sb_i   (n11_q),
    .vld_o  (vld_f),
    .root_o (root_f),
    .sb_o   (n_f)
  );

  // stage 12: speed clamp test and rescale numerators
  clamp_sb_t        c12_d, c12_q, c_g;
  logic [2:0][30:0] dnum12_d, dnum12_q;
  logic [15:0]      nm12_q;

  always_comb begin
    c12_d.live     = n_f.live;
    c12_d.at_tgt   = n_f.at_tgt;
    c12_d.brake_ok = n_f.brake_ok;
    c12_d.rb       = n_f.rb;
    c12_d.want     = n_f.want;
    c12_d.reach    = n_f.reach;
    c12_d.rv       = n_f.rv;
    c12_d.rneg     = n_f.rneg;
    c12_d.clamp    = root_f[0] > {1'b0, max_speed_q};
    for (int i = 0; i < 3; i++) begin
      dnum12_d[i] = n_f.rmag[i] * max_speed_q;
    end
  end

  pipe_ctrl_t       ctrl_g;
  logic [2:0][15:0] den_g;
  logic [2:0][15:0] quo_g;

  assign ctrl_g = '{en: adv, vld: v12_q};
  assign den_g  = {nm12_q, nm12_q, nm12_q};

  avl_div #(.NW(31), .DW(16), .QW(16), .LANES(3), .SW($bits(clamp_sb_t))) u_div_clamp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl_g),
    .num_i  (dnum12_q),
    .den_i  (den_g),
    .sb_i   (c12_q),
    .vld_o  (vld_g),
    .quo_o  (quo_g),
    .sb_o   (c_g)
  );

  // output stage: pick the result by case
  logic [2:0][15:0] rc;
  logic [2:0][15:0] res_d, res_q;
  logic [2:0]       mode_d, mode_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rc[i] = c_g.rneg[i] ? 16'd0 - quo_g[i] : quo_g[i];
    end
    if (!c_g.live) begin
      res_d  = '0;
      mode_d = MODE_ZERO;
    end else if (c_g.at_tgt) begin
      res_d  = c_g.brake_ok ? c_g.rb : '0;
      mode_d = c_g.brake_ok ? MODE_BRAKE : MODE_ZERO;
    end else if (c_g.reach) begin
      res_d  = c_g.want;
      mode_d = MODE_REACHED;
    end else if (c_g.clamp) begin
      res_d  = rc;
      mode_d = MODE_CLAMP;
    end else begin
      res_d  = c_g.rv;
      mode_d = MODE_ACCEL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      v8_q        <= 1'b0;
      v9_q        <= 1'b0;
      v10_q       <= 1'b0;
      v11_q       <= 1'b0;
      v12_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v0_q        <= in_valid_i;
      v1_q        <= v0_q;
      v2_q        <= v1_q;
      v3_q        <= vld_a;
      v4_q        <= vld_b;
      v5_q        <= vld_c;
      v6_q        <= v5_q;
      v7_q        <= v6_q;
      v8_q        <= vld_d;
      v9_q        <= vld_e;
      v10_q       <= v9_q;
      v11_q       <= v10_q;
      v12_q       <= vld_f;
      out_valid_q <= vld_g;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f0_q <= f0_d;
      f1_q <= f0_q;
      f2_q <= f1_q;
      for (int i = 0; i < 3; i++) begin
        sqd1_q[i]  <= f0_q.dmag[i] * f0_q.dmag[i];
        sqv1_q[i]  <= f0_q.vmag[i] * f0_q.vmag[i];
        sqf6_q[i]  <= df5_q.fmag[i] * df5_q.fmag[i];
        sqr10_q[i] <= n9_q.rmag[i] * n9_q.rmag[i];
      end
      sd2_q    <= 50'(sqd1_q[0]) + 50'(sqd1_q[1]) + 50'(sqd1_q[2]);
      sv2_q    <= sqv1_q[0] + sqv1_q[1] + sqv1_q[2];
      sp3_q    <= sp3_d;
      nump3_q  <= nump3_d;
      bnum3_q  <= bnum3_d;
      w4_q     <= w4_d;
      wnum4_q  <= wnum4_d;
      dist4_q  <= sp_b.dlen;
      df5_q    <= df5_d;
      df6_q    <= df5_q;
      df7_q    <= df6_q;
      sf7_q    <= sqf6_q[0] + sqf6_q[1] + sqf6_q[2];
      st8_q    <= st8_d;
      cnum8_q  <= cnum8_d;
      dm8_q    <= root_d[0];
      n9_q     <= n9_d;
      n10_q    <= n9_q;
      n11_q    <= n10_q;
      sr11_q   <= sqr10_q[0] + sqr10_q[1] + sqr10_q[2];
      c12_q    <= c12_d;
      dnum12_q <= dnum12_d;
      nm12_q   <= root_f[0];
      res_q    <= res_d;
      mode_q   <= mode_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_vel_x_o = res_q[0];
  assign new_vel_y_o = res_q[1];
  assign new_vel_z_o = res_q[2];
  assign mode_o      = mode_q;

endmodule

`default_nettype wire
